FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expands to one labeled concurrent assertion that is sampled
// on the rising clock edge and is off while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define HTD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define HTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types, widths and helpers of the Huffman tree bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  // fixed field widths
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned IN_SYM_W  = 8;
  localparam int unsigned OUT_SYM_W = 8;

  // item operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // node memory control, one write and one read port
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } mem_ctl_t;

  // true when a node index addresses an existing entry
  function automatic logic idx_in_range(logic [IDX_W-1:0] idx, int unsigned count);
    return 32'(idx) < count;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/huffman_tree_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit
// Walks a Huffman code tree held in a node memory, one code bit per beat.
// ----------------------------------------------------------------------------
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_ready_o | op, node_index, children, leaf, bit
//   out     | out | out_valid_o/out_ready_i | symbol_o
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_root_node_i
//
// A node write holds off no later beat. A decode beat holds off none either
// when the node it stands on is a leaf; otherwise in is held off while the child's
// word comes back from the synchronous node memory in the cycle after its address is issued.
// The current and root node words are cached in registers and kept coherent
// by forwarding node writes, so each bit needs at most one memory read.
// A root write makes the unit reload the root word from memory; in and cfg are
// held off meanwhile, and in is held off while a cfg beat is offered.
// Reset puts the walk and the root at node 0. Results go through a
// two-entry queue; input also stalls while it is full and out_ready_i is low.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder_unit #(
  parameter int unsigned NODE_COUNT   = 512,
  parameter int unsigned SYMBOL_WIDTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // item channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic [htd_pkg::IDX_W-1:0]      node_index_i,
  input  wire logic [htd_pkg::IDX_W-1:0]      left_child_i,
  input  wire logic [htd_pkg::IDX_W-1:0]      right_child_i,
  input  wire logic                           leaf_flag_i,
  input  wire logic [htd_pkg::IN_SYM_W-1:0]   leaf_symbol_i,
  input  wire logic                           code_bit_i,
  input  wire logic                           restart_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [htd_pkg::OUT_SYM_W-1:0]  symbol_o,
  // root register write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [htd_pkg::IDX_W-1:0]      cfg_root_node_i
);
  import htd_pkg::*;

  // node word: {left, right, leaf, symbol}
  localparam int unsigned NODE_W  = 2 * IDX_W + 1 + SYMBOL_WIDTH;
  localparam int unsigned LEAF_B  = SYMBOL_WIDTH;
  localparam int unsigned RIGHT_L = SYMBOL_WIDTH + 1;
  localparam int unsigned LEFT_L  = SYMBOL_WIDTH + 1 + IDX_W;

  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [IDX_W-1:0]     root_q, root_d;
  logic [IDX_W-1:0]     nxt_q, nxt_d;
  logic [NODE_W-1:0]    cur_w_q, cur_w_d;
  logic [NODE_W-1:0]    root_w_q, root_w_d;
  logic                 pend_q, pend_d;
  logic                 refill_q, refill_d;

  mem_ctl_t             mem_ctl;
  logic [NODE_W-1:0]    wr_word;
  logic [NODE_W-1:0]    rd_word;
  logic [NODE_W-1:0]    sel_w;
  logic [IDX_W-1:0]     child;
  logic                 wr_hit_ok;

  logic                 fifo_push;
  logic [OUT_SYM_W-1:0] fifo_push_data;
  logic                 fifo_pop;
  logic                 fifo_full;

  logic                 cfg_fire;
  logic                 in_fire;
  logic                 wr_fire;
  logic                 dec_fire;

  // handshakes; a pending root write wins over an item beat
  assign cfg_ready_o = !pend_q && !refill_q;
  assign in_ready_o  = !pend_q && !refill_q && !cfg_valid_i &&
                       (!fifo_full || out_ready_i);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign wr_fire     = in_fire && (op_i == OP_WRITE);
  assign dec_fire    = in_fire && (op_i == OP_DECODE);
  assign fifo_pop    = out_valid_o && out_ready_i;

  // word of a write beat, symbol kept to SYMBOL_WIDTH bits
  assign wr_word   = {left_child_i, right_child_i, leaf_flag_i,
                      SYMBOL_WIDTH'(leaf_symbol_i)};
  assign wr_hit_ok = idx_in_range(node_index_i, NODE_COUNT);

  // node the bit starts from, after an optional restart
  assign sel_w = restart_i ? root_w_q : cur_w_q;
  assign child = code_bit_i ? sel_w[RIGHT_L +: IDX_W] : sel_w[LEFT_L +: IDX_W];

  // walk control and cache upkeep
  always_comb begin
    cur_d          = cur_q;
    root_d         = root_q;
    nxt_d          = nxt_q;
    cur_w_d        = cur_w_q;
    root_w_d       = root_w_q;
    pend_d         = 1'b0;
    refill_d       = 1'b0;
    mem_ctl        = '0;
    fifo_push      = 1'b0;
    fifo_push_data = OUT_SYM_W'(sel_w[SYMBOL_WIDTH-1:0]);

    priority if (refill_q) begin
      // root word back from memory
      cur_w_d  = rd_word;
      root_w_d = rd_word;
    end else if (pend_q) begin
      // child word back from memory
      if (rd_word[LEAF_B]) begin
        fifo_push      = 1'b1;
        fifo_push_data = OUT_SYM_W'(rd_word[SYMBOL_WIDTH-1:0]);
        cur_d          = root_q;
        cur_w_d        = root_w_q;
      end else begin
        cur_d   = nxt_q;
        cur_w_d = rd_word;
      end
    end else if (cfg_fire) begin
      root_d         = cfg_root_node_i;
      cur_d          = cfg_root_node_i;
      refill_d       = 1'b1;
      mem_ctl.rd_en  = 1'b1;
      mem_ctl.rd_idx = cfg_root_node_i;
    end else if (wr_fire) begin
      mem_ctl.wr_en  = 1'b1;
      mem_ctl.wr_idx = node_index_i;
      if (wr_hit_ok && (node_index_i == cur_q)) begin
        cur_w_d = wr_word;
      end
      if (wr_hit_ok && (node_index_i == root_q)) begin
        root_w_d = wr_word;
      end
    end else if (dec_fire) begin
      if (sel_w[LEAF_B]) begin
        fifo_push = 1'b1;
        cur_d     = root_q;
        cur_w_d   = root_w_q;
      end else begin
        pend_d         = 1'b1;
        nxt_d          = child;
        mem_ctl.rd_en  = 1'b1;
        mem_ctl.rd_idx = child;
      end
    end else begin
      // idle: walk state holds
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      root_q   <= '0;
      nxt_q    <= '0;
      cur_w_q  <= '0;
      root_w_q <= '0;
      pend_q   <= 1'b0;
      refill_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      root_q   <= root_d;
      nxt_q    <= nxt_d;
      cur_w_q  <= cur_w_d;
      root_w_q <= root_w_d;
      pend_q   <= pend_d;
      refill_q <= refill_d;
    end
  end

  htd_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .NODE_W     (NODE_W)
  ) u_node_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  htd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_push_data),
    .pop_i       (fifo_pop),
    .valid_o     (out_valid_o),
    .full_o      (fifo_full),
    .data_o      (symbol_o)
  );

endmodule

`default_nettype wire

FILE: rtl/htd_node_mem.sv
// ----------------------------------------------------------------------------
// htd_node_mem
// Tree node store: one write port, one read port, registered read data.
// Indices past the end are dropped on write and read back as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_node_mem #(
  parameter int unsigned NODE_COUNT = 512,
  parameter int unsigned NODE_W     = 27
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire htd_pkg::mem_ctl_t   ctl_i,
  input  wire logic [NODE_W-1:0]   wr_data_i,
  output logic      [NODE_W-1:0]   rd_data_o
);
  import htd_pkg::*;

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [NODE_W-1:0] mem [NODE_COUNT];
  logic [NODE_W-1:0] rd_q;
  logic              oor_q;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              wr_ok;
  logic              rd_ok;

  assign wr_addr = AW'(ctl_i.wr_idx);
  assign rd_addr = AW'(ctl_i.rd_idx);
  assign wr_ok   = idx_in_range(ctl_i.wr_idx, NODE_COUNT);
  assign rd_ok   = idx_in_range(ctl_i.rd_idx, NODE_COUNT);

  // array write and read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && wr_ok) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en && rd_ok) begin
      rd_q <= mem[rd_addr];
    end
  end

  // remember a read past the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oor_q <= 1'b0;
    end else if (ctl_i.rd_en) begin
      oor_q <= !rd_ok;
    end
  end

  assign rd_data_o = oor_q ? '0 : rd_q;

endmodule

`default_nettype wire

FILE: rtl/htd_out_fifo.sv
// ----------------------------------------------------------------------------
// htd_out_fifo
// Two-entry result queue between the tree walker and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_out_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [htd_pkg::OUT_SYM_W-1:0]  push_data_i,
  input  wire logic                           pop_i,
  output logic                                valid_o,
  output logic                                full_o,
  output logic      [htd_pkg::OUT_SYM_W-1:0]  data_o
);
  import htd_pkg::*;

  logic [OUT_SYM_W-1:0] entry_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks of the Huffman tree bit decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module htd_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           op_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [htd_pkg::OUT_SYM_W-1:0]  symbol_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o
);
  import htd_pkg::*;

  logic dec_beat;
  assign dec_beat = in_valid_i && in_ready_o && (op_i == OP_DECODE);

  // a stalled result holds its value
  `HTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(symbol_o), "stalled result beat changed")

  // root write is followed by the reload cycle
  `HTD_ASSERT_NEXT(a_cfg_reload, clk_i, rst_ni, cfg_valid_i && cfg_ready_o,
    !in_ready_o && !cfg_ready_o, "input taken during root reload")

  // a result appears only after a decode beat, directly on a leaf or after the child read
  `HTD_ASSERT_SAME(a_out_src, clk_i, rst_ni, $rose(out_valid_o),
    $past(dec_beat) || $past(dec_beat, 2), "result without a decode beat")

  // the item port is never open while the root port is busy
  `HTD_ASSERT_SAME(a_ready_order, clk_i, rst_ni, in_ready_o,
    cfg_ready_o, "input ready while root port busy")

endmodule

bind huffman_tree_bit_decoder_unit htd_checker u_htd_checker (.*);

`default_nettype wire

FILE: test/tb_huffman_tree_bit_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_bit_decoder_unit
// Self-checking bench for the Huffman tree-walk bit decoder. Code trees are
// built bottom-up at random node indices, the root register is pointed at
// them, and random bit streams with restarts and in-flight node rewrites are
// fed in. A local tree walker predicts every decoded symbol at input
// acceptance; the output monitor checks each symbol beat in order.
// ----------------------------------------------------------------------------

module tb_huffman_tree_bit_decoder_unit;
  import htd_pkg::*;

  localparam int unsigned NODES = 512;

  // one input beat
  typedef struct packed {
    op_e                 op;
    logic [IDX_W-1:0]    node_index;
    logic [IDX_W-1:0]    left_child;
    logic [IDX_W-1:0]    right_child;
    logic                leaf_flag;
    logic [IN_SYM_W-1:0] leaf_symbol;
    logic                code_bit;
    logic                restart;
  } bit_item_t;

  // one node memory entry
  typedef struct packed {
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
    logic                leaf;
    logic [IN_SYM_W-1:0] sym;
  } tree_node_t;

  // DUT ports
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  op_i            = 1'b0;
  logic [IDX_W-1:0]      node_index_i    = '0;
  logic [IDX_W-1:0]      left_child_i    = '0;
  logic [IDX_W-1:0]      right_child_i   = '0;
  logic                  leaf_flag_i     = 1'b0;
  logic [IN_SYM_W-1:0]   leaf_symbol_i   = '0;
  logic                  code_bit_i      = 1'b0;
  logic                  restart_i       = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [OUT_SYM_W-1:0]  symbol_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_root_node_i = '0;

  // stimulus and checking state
  bit_item_t             item_q [$];
  bit_item_t             drv_item;
  logic [OUT_SYM_W-1:0]  symbol_expect_q [$];
  int unsigned           errors     = 0;
  int unsigned           in_beats   = 0;
  int unsigned           sym_beats  = 0;
  int unsigned           items_made = 0;
  int unsigned           stall_left = 0;
  bit                    hold_done  = 1'b0;
  logic                  calm;

  // tree walker copy
  tree_node_t            tree_mem [NODES];
  logic [IDX_W-1:0]      walk_root = '0;
  logic [IDX_W-1:0]      walk_cur  = '0;

  // generator bookkeeping: nodes that may be referenced as children
  bit                    gen_written [NODES];
  bit                    phase_used  [NODES];
  logic [IDX_W-1:0]      written_list [$];

  huffman_tree_bit_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .node_index_i    (node_index_i),
    .left_child_i    (left_child_i),
    .right_child_i   (right_child_i),
    .leaf_flag_i     (leaf_flag_i),
    .leaf_symbol_i   (leaf_symbol_i),
    .code_bit_i      (code_bit_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_o        (symbol_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_root_node_i (cfg_root_node_i)
  );

  always #5 clk_i = ~clk_i;

  // no idling on either side through this window
  assign calm = (in_beats >= 300) && (in_beats < 420);

  // walk one accepted beat through the local tree copy
  task automatic advance_walk(input bit_item_t it);
    tree_node_t here;
    tree_node_t child;
    logic [IDX_W-1:0] nxt;
    if (it.op == OP_WRITE) begin
      here.left  = it.left_child;
      here.right = it.right_child;
      here.leaf  = it.leaf_flag;
      here.sym   = it.leaf_symbol;
      tree_mem[it.node_index] = here;
    end else begin
      if (it.restart) walk_cur = walk_root;
      here = tree_mem[walk_cur];
      if (here.leaf) begin
        // standing on a rewritten leaf: emit it without following a child
        symbol_expect_q.push_back(here.sym);
        walk_cur = walk_root;
      end else begin
        nxt   = it.code_bit ? here.right : here.left;
        child = tree_mem[nxt];
        if (child.leaf) begin
          symbol_expect_q.push_back(child.sym);
          walk_cur = walk_root;
        end else begin
          walk_cur = nxt;
        end
      end
    end
  endtask

  // queue a node write; unused fields carry random junk
  task automatic push_write(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] l,
                            input logic [IDX_W-1:0] r, input logic leaf,
                            input logic [IN_SYM_W-1:0] sym);
    bit_item_t it;
    it.op          = OP_WRITE;
    it.node_index  = idx;
    it.left_child  = l;
    it.right_child = r;
    it.leaf_flag   = leaf;
    it.leaf_symbol = sym;
    it.code_bit    = 1'($urandom_range(0, 1));
    it.restart     = 1'($urandom_range(0, 1));
    item_q.push_back(it);
    items_made++;
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // queue a decode bit; node fields carry random junk
  task automatic push_decode(input logic cbit, input logic rst_walk);
    bit_item_t it;
    it.op          = OP_DECODE;
    it.node_index  = IDX_W'($urandom_range(0, NODES - 1));
    it.left_child  = IDX_W'($urandom_range(0, NODES - 1));
    it.right_child = IDX_W'($urandom_range(0, NODES - 1));
    it.leaf_flag   = 1'($urandom_range(0, 1));
    it.leaf_symbol = IN_SYM_W'($urandom_range(0, 255));
    it.code_bit    = cbit;
    it.restart     = rst_walk;
    item_q.push_back(it);
    items_made++;
  endtask

  function automatic logic [IDX_W-1:0] pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // distinct node index within a phase, biased toward the ends
  task automatic take_index(output logic [IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) idx = '1;
    else if (roll == 1) idx = '0;
    else idx = IDX_W'($urandom_range(0, NODES - 1));
    while (phase_used[idx]) idx = IDX_W'($urandom_range(0, NODES - 1));
    phase_used[idx] = 1'b1;
  endtask

  // leaves first, then pair subtrees until one root is left
  task automatic build_tree(input int unsigned leaves, output logic [IDX_W-1:0] top);
    logic [IDX_W-1:0] pool [$];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int unsigned k;
    for (k = 0; k < leaves; k++) begin
      take_index(idx);
      push_write(idx, IDX_W'($urandom_range(0, NODES - 1)),
                 IDX_W'($urandom_range(0, NODES - 1)), 1'b1,
                 IN_SYM_W'($urandom_range(0, 255)));
      pool.push_back(idx);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(0, pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      take_index(idx);
      push_write(idx, a, b, 1'b0, IN_SYM_W'($urandom_range(0, 255)));
      pool.push_back(idx);
    end
    top = pool[0];
  endtask

  // drain everything, then let a write or a silent bit finish inside
  task automatic wait_idle();
    while (item_q.size() != 0 || in_beats != items_made || symbol_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // root register write; the walk restarts at the new root
  task automatic write_root(input logic [IDX_W-1:0] value);
    cfg_valid_i     <= 1'b1;
    cfg_root_node_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    walk_root = value;
    walk_cur  = value;
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_walk(drv_item);
        in_beats++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          drv_item       = item_q.pop_front();
          op_i          <= drv_item.op;
          node_index_i  <= drv_item.node_index;
          left_child_i  <= drv_item.left_child;
          right_child_i <= drv_item.right_child;
          leaf_flag_i   <= drv_item.leaf_flag;
          leaf_symbol_i <= drv_item.leaf_symbol;
          code_bit_i    <= drv_item.code_bit;
          restart_i     <= drv_item.restart;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready pattern
  always @(posedge clk_i) begin
    logic [OUT_SYM_W-1:0] exp_sym;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        sym_beats++;
        if (symbol_expect_q.size() == 0) begin
          $error("symbol: expected none, got %0d", symbol_o);
          errors++;
        end else begin
          exp_sym = symbol_expect_q.pop_front();
          if (symbol_o !== exp_sym) begin
            $error("symbol: expected %0d, got %0d", exp_sym, symbol_o);
            errors++;
          end
        end
      end
      // one long hold-off so the result queue fills and input backs up
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!hold_done && sym_beats >= 30 && item_q.size() > 8) begin
        out_ready_i <= 1'b0;
        stall_left = 250;
        hold_done  = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL huffman_tree_bit_decoder_unit");
    $finish;
  end

  // stimulus
  initial begin
    logic [IDX_W-1:0] top;
    int unsigned leaves;
    int unsigned n;
    int unsigned k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed tree at the reset root: 0 -> (511 leaf, 1 -> (2 leaf, 511))
    push_write(9'd511, 9'h1FF, 9'h1FF, 1'b1, 8'hFF);
    push_write(9'd2, 9'd0, 9'd0, 1'b1, 8'h00);
    push_write(9'd1, 9'd2, 9'd511, 1'b0, 8'h3C);
    push_write(9'd0, 9'd511, 9'd1, 1'b0, 8'hA5);
    push_decode(1'b0, 1'b0);
    push_decode(1'b1, 1'b0);
    push_decode(1'b0, 1'b0);
    push_decode(1'b1, 1'b0);
    push_decode(1'b1, 1'b0);
    // restart in mid-walk
    push_decode(1'b1, 1'b0);
    push_decode(1'b0, 1'b1);
    // current node rewritten as a leaf while the walk stands on it
    push_decode(1'b1, 1'b0);
    push_write(9'd1, 9'd0, 9'd511, 1'b1, 8'h5A);
    push_decode(1'b0, 1'b0);
    push_decode(1'b1, 1'b0);
    push_write(9'd1, 9'd2, 9'd511, 1'b0, 8'hC3);
    wait_idle();
    // root is a leaf: every bit gives the root symbol
    write_root(9'd511);
    push_decode(1'b0, 1'b0);
    push_decode(1'b1, 1'b1);
    wait_idle();
    write_root(9'd0);
    push_decode(1'b1, 1'b0);
    push_decode(1'b1, 1'b0);

    // random trees with random bit streams
    while (items_made < 600) begin
      for (k = 0; k < NODES; k++) phase_used[k] = 1'b0;
      leaves = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
      build_tree(leaves, top);
      wait_idle();
      write_root(top);
      n = $urandom_range(20, 60);
      repeat (n) begin
        if ($urandom_range(0, 99) < 6) begin
          // in-flight rewrite, children always point at written nodes
          push_write(($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, NODES - 1))
                                                 : pick_written(),
                     pick_written(), pick_written(), 1'($urandom_range(0, 1)),
                     IN_SYM_W'($urandom_range(0, 255)));
        end else begin
          push_decode(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 4);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS huffman_tree_bit_decoder_unit");
    end else begin
      $display("FAIL huffman_tree_bit_decoder_unit");
    end
    $finish;
  end

endmodule
